[hw/rtl/vn3_pkg.sv]
package vn3_pkg;

	// Input coordinate format
	localparam int FRAC_BITS = 16;
	localparam int FRAC_UP   = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;
	localparam int FRAC_DN   = (FRAC_BITS > 16) ? (FRAC_BITS - 16) : 0;
	localparam logic [31:0] FRAC_MASK = 32'((64'd1 << FRAC_BITS) - 64'd1);

	// Lattice hash constants
	localparam logic [31:0] HASH_MUL_Y   = 32'd374761393;
	localparam logic [31:0] HASH_MUL_Z   = 32'd668265263;
	localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;
	localparam int          HASH_SHIFT_A = 13;
	localparam int          HASH_SHIFT_B = 16;
	localparam logic [16:0] HASH_MAX     = 17'd32767;

	// Smoothstep: 3.0 in Q.16
	localparam logic [17:0] SMOOTH_THREE = 18'd196608;

	// Corner value rounding thresholds on |2m - 32767|
	localparam logic [14:0] RND_STEP1 = 15'd8192;
	localparam logic [14:0] RND_STEP2 = 15'd24576;

	localparam int VAL_W  = 18;
	localparam int LATENCY = 11;

	typedef logic signed [VAL_W-1:0] val_t;

endpackage

[hw/rtl/value_noise_3d_hashed.sv]
// 3-D hashed value noise. Give a signed Q16.16 point on point_x/y/z with start;
// once it has passed the register stages s1 to s11, done is high for one cycle
// with noise_value, a signed Q.16 number in [-1, 1]. busy is never raised, so a
// new point may be started in every cycle and results come out in order, one per
// cycle at full load. The result is shown for that single cycle only and must be
// taken then. The latency is set by the chain of multiplies: coordinate hash,
// hash mix, then the x, y and z blends, each in its own register stages.
module value_noise_3d_hashed (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [31:0]   point_x,
	input  logic signed [31:0]   point_y,
	input  logic signed [31:0]   point_z,
	output logic                 done,
	output vn3_pkg::val_t        noise_value
);
	import vn3_pkg::*;

	function automatic val_t corner_value(input logic [31:0] hm);
		logic [31:0]        h;
		logic signed [16:0] k;
		logic [14:0]        mag;
		logic [16:0]        v;
		h   = hm ^ (hm >> HASH_SHIFT_B);
		k   = $signed({2'b00, h[14:0]} << 1) - $signed(HASH_MAX);
		mag = k[16] ? 15'(-k) : k[14:0];
		v   = {1'b0, mag, 1'b0} + 17'(mag >= RND_STEP1) + 17'(mag >= RND_STEP2);
		corner_value = k[16] ? -$signed({1'b0, v}) : $signed({1'b0, v});
	endfunction

	function automatic logic signed [37:0] lerp_mul(input val_t a, input val_t b,
			input logic [16:0] t);
		logic signed [19:0] d;
		d = 20'(b) - 20'(a);
		lerp_mul = d * $signed({1'b0, t});
	endfunction

	function automatic val_t lerp_add(input val_t a, input logic signed [37:0] p);
		logic signed [21:0] s;
		s = 22'(a) + 22'(p >>> 16);
		lerp_add = s[VAL_W-1:0];
	endfunction

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic               vld_s7, vld_s8, vld_s9, vld_s10, vld_s11;

	logic [31:0]        pnt [3];
	logic [31:0]        cell0_s1 [3];
	logic [31:0]        cell1_s1 [3];
	logic [15:0]        frac_s1 [3];

	logic [31:0]        ix0_s2, ix1_s2;
	logic [31:0]        ym_s2 [2];
	logic [31:0]        zm_s2 [2];
	logic [15:0]        fsq_s2 [3];
	logic [17:0]        fd_s2 [3];

	logic [31:0]        g_s3 [8];
	logic [16:0]        sm_s3 [3];
	logic [31:0]        hm_s4 [8];
	logic [16:0]        sm_s4 [3];
	val_t               cv_s5 [8];
	logic [16:0]        sm_s5 [3];

	logic signed [37:0] px_s6 [4];
	val_t               ax_s6 [4];
	logic [16:0]        v_s6, w_s6;
	val_t               x_s7 [4];
	logic [16:0]        v_s7, w_s7;
	logic signed [37:0] py_s8 [2];
	val_t               ay_s8 [2];
	logic [16:0]        w_s8;
	val_t               y_s9 [2];
	logic [16:0]        w_s9;
	logic signed [37:0] pz_s10;
	val_t               az_s10;
	val_t               r_s11;

	assign busy = 1'b0;
	assign pnt[0] = point_x;
	assign pnt[1] = point_y;
	assign pnt[2] = point_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else begin
			vld_s1  <= start;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	// Data path: no stall, so the payload simply flows every cycle
	always_ff @(posedge clk) begin
		// s1: cell corners and Q0.16 fractions
		for (int a = 0; a < 3; a++) begin
			cell0_s1[a] <= 32'($signed(pnt[a]) >>> FRAC_BITS);
			cell1_s1[a] <= 32'($signed(pnt[a]) >>> FRAC_BITS) + 32'd1;
			frac_s1[a]  <= 16'(((pnt[a] & FRAC_MASK) << FRAC_UP) >> FRAC_DN);
		end

		// s2: hash products on y and z, smoothstep first half
		ix0_s2 <= cell0_s1[0];
		ix1_s2 <= cell1_s1[0];
		ym_s2[0] <= 32'(cell0_s1[1] * HASH_MUL_Y);
		ym_s2[1] <= 32'(cell1_s1[1] * HASH_MUL_Y);
		zm_s2[0] <= 32'(cell0_s1[2] * HASH_MUL_Z);
		zm_s2[1] <= 32'(cell1_s1[2] * HASH_MUL_Z);
		for (int a = 0; a < 3; a++) begin
			fsq_s2[a] <= 16'(({16'd0, frac_s1[a]} * {16'd0, frac_s1[a]}) >> 16);
			fd_s2[a]  <= SMOOTH_THREE - {1'b0, frac_s1[a], 1'b0};
		end

		// s3: combine per corner; corner index bit 0 = x, bit 1 = y, bit 2 = z
		for (int c = 0; c < 8; c++) begin
			logic [31:0] h;
			h = (c[0] ? ix1_s2 : ix0_s2) ^ ym_s2[c[1]] ^ zm_s2[c[2]];
			g_s3[c] <= h ^ (h >> HASH_SHIFT_A);
		end
		for (int a = 0; a < 3; a++) begin
			logic [33:0] p;
			p = {18'd0, fsq_s2[a]} * {16'd0, fd_s2[a]};
			sm_s3[a] <= p[32:16];
		end

		// s4: hash mix multiply
		for (int c = 0; c < 8; c++)
			hm_s4[c] <= 32'(g_s3[c] * HASH_MUL_MIX);
		sm_s4 <= sm_s3;

		// s5: corner values
		for (int c = 0; c < 8; c++)
			cv_s5[c] <= corner_value(hm_s4[c]);
		sm_s5 <= sm_s4;

		// s6/s7: blend along x
		for (int q = 0; q < 4; q++) begin
			px_s6[q] <= lerp_mul(cv_s5[2*q], cv_s5[2*q+1], sm_s5[0]);
			ax_s6[q] <= cv_s5[2*q];
		end
		v_s6 <= sm_s5[1];
		w_s6 <= sm_s5[2];
		for (int q = 0; q < 4; q++)
			x_s7[q] <= lerp_add(ax_s6[q], px_s6[q]);
		v_s7 <= v_s6;
		w_s7 <= w_s6;

		// s8/s9: blend along y
		for (int r = 0; r < 2; r++) begin
			py_s8[r] <= lerp_mul(x_s7[2*r], x_s7[2*r+1], v_s7);
			ay_s8[r] <= x_s7[2*r];
		end
		w_s8 <= w_s7;
		for (int r = 0; r < 2; r++)
			y_s9[r] <= lerp_add(ay_s8[r], py_s8[r]);
		w_s9 <= w_s8;

		// s10/s11: blend along z
		pz_s10 <= lerp_mul(y_s9[0], y_s9[1], w_s9);
		az_s10 <= y_s9[0];
		r_s11  <= lerp_add(az_s10, pz_s10);
	end

	assign done        = vld_s11;
	assign noise_value = r_s11;

endmodule

[hw/rtl/vn3_chk.sv]
module vn3_chk (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic signed [31:0]   point_x,
	input  logic signed [31:0]   point_y,
	input  logic signed [31:0]   point_z,
	input  logic                 done,
	input  vn3_pkg::val_t        noise_value
);
	import vn3_pkg::*;

	// every started item comes out after the fixed latency
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("item started but no result after pipeline latency");

	// no result without an item started the matching number of cycles before
	a_done_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a started item");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($signed(noise_value) >= -65536 && $signed(noise_value) <= 65536))
		else $error("noise value out of range");

	// same point twice in a row gives the same value twice
	a_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && $past(start) && $past(arst_n) && point_x == $past(point_x) &&
			point_y == $past(point_y) && point_z == $past(point_z))
		|-> ##LATENCY (noise_value == $past(noise_value)))
		else $error("repeated point gave a different value");

endmodule

bind value_noise_3d_hashed vn3_chk u_vn3_chk (.*);
